// ===== sv/lac_pkg.sv =====
// Shared constants, command and status types for the linear ADRC controller.
`default_nettype none

package lac_pkg;

   localparam int DATA_W     = 32;
   localparam int GAIN_W     = 48;
   localparam int REG_COUNT  = 8;
   localparam int REG_IDX_W  = 3;
   localparam int CSR_IDX_W  = 4;
   localparam int OUT_LIMIT_DEF = 5;

   // Register indexes; the gain select of a multiply uses the same codes.
   localparam logic [REG_IDX_W-1:0] REG_OBS_GAIN_POS    = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_OBS_GAIN_RATE   = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_OBS_GAIN_DIST   = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_INPUT_GAIN_STEP = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_TIME_STEP       = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_PROP_GAIN       = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_DERIV_GAIN      = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_INV_PLANT_GAIN  = 3'd7;

   localparam logic signed [GAIN_W-1:0] GAIN_RESET [REG_COUNT] = '{
      48'sd3774873,
      48'sd2831155200,
      48'sd707788800000,
      48'sd2998004,
      48'sd1678,
      48'sd377487360000,
      48'sd5033164800,
      48'sd9389
   };

   // Multiplier operand codes.
   localparam int OPD_W = 3;
   localparam logic [OPD_W-1:0] OPD_RATE = 3'd0;
   localparam logic [OPD_W-1:0] OPD_DIST = 3'd1;
   localparam logic [OPD_W-1:0] OPD_E    = 3'd2;
   localparam logic [OPD_W-1:0] OPD_LAST = 3'd3;
   localparam logic [OPD_W-1:0] OPD_ERR  = 3'd4;
   localparam logic [OPD_W-1:0] OPD_U0   = 3'd5;

   // Accumulator preload codes.
   localparam int ASRC_W = 3;
   localparam logic [ASRC_W-1:0] ASRC_ZERO     = 3'd0;
   localparam logic [ASRC_W-1:0] ASRC_POS      = 3'd1;
   localparam logic [ASRC_W-1:0] ASRC_RATE     = 3'd2;
   localparam logic [ASRC_W-1:0] ASRC_DIST     = 3'd3;
   localparam logic [ASRC_W-1:0] ASRC_NEG_DIST = 3'd4;

   // Write-back destination codes.
   localparam int WB_W = 2;
   localparam logic [WB_W-1:0] WB_POS  = 2'd0;
   localparam logic [WB_W-1:0] WB_RATE = 2'd1;
   localparam logic [WB_W-1:0] WB_DIST = 2'd2;
   localparam logic [WB_W-1:0] WB_U0   = 2'd3;

   typedef struct packed {
      logic                  take;
      logic                  mul_en;
      logic                  mul_hi;
      logic                  mul_neg;
      logic [REG_IDX_W-1:0]  gain_sel;
      logic [OPD_W-1:0]      opnd_sel;
      logic                  acc_load;
      logic [ASRC_W-1:0]     acc_src;
      logic                  wb_en;
      logic [WB_W-1:0]       wb_dst;
      logic                  err_load;
      logic                  finish;
   } lac_cmd_type;

   typedef struct packed {
      logic in_valid;
      logic out_free;
   } lac_status_type;

endpackage

`default_nettype wire

// ===== sv/lac_if.sv =====
// Handshake channel interfaces for requests, results and register writes.
`default_nettype none

interface lac_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [lac_pkg::DATA_W-1:0]    setpoint;
   logic signed [lac_pkg::DATA_W-1:0]    measured;
   modport source (output valid, setpoint, measured, input ready);
   modport sink (input valid, setpoint, measured, output ready);
endinterface

interface lac_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [lac_pkg::DATA_W-1:0]    drive;
   logic                                 clamped;
   modport source (output valid, drive, clamped, input ready);
   modport sink (input valid, drive, clamped, output ready);
endinterface

interface lac_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [lac_pkg::CSR_IDX_W-1:0]        index;
   logic [lac_pkg::GAIN_W-1:0]           data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/lac_ctrl.sv =====
// Sequencer that steps the shared multiply-accumulate datapath through one item.
`default_nettype none

module lac_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire lac_pkg::lac_status_type status,
   output lac_pkg::lac_cmd_type         cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   localparam int STEP_W = 6;
   // First step of each sum: observer position, rate, disturbance, control sum, drive.
   localparam int S_P  = 0;
   localparam int S_R  = 7;
   localparam int S_D  = 16;
   localparam int S_U0 = 21;
   localparam int S_U  = 28;
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(S_U + 4);

   logic              state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   function automatic lac_pkg::lac_cmd_type mul_cmd(
      input logic                            hi,
      input logic [lac_pkg::REG_IDX_W-1:0]   gsel,
      input logic [lac_pkg::OPD_W-1:0]       opnd,
      input logic                            neg
   );
      lac_pkg::lac_cmd_type c;
      c          = '0;
      c.mul_en   = 1'b1;
      c.mul_hi   = hi;
      c.mul_neg  = neg;
      c.gain_sel = gsel;
      c.opnd_sel = opnd;
      return c;
   endfunction

   // Each product takes two passes, high half first. A sum is read once the accumulate
   // stages have drained after its last pass.
   function automatic lac_pkg::lac_cmd_type ucode(input logic [STEP_W-1:0] s);
      lac_pkg::lac_cmd_type c;
      c = '0;
      case (s)
         STEP_W'(S_P + 0): begin
            c = mul_cmd(1'b1, lac_pkg::REG_TIME_STEP, lac_pkg::OPD_RATE, 1'b0);
            c.acc_load = 1'b1;
            c.acc_src  = lac_pkg::ASRC_POS;
         end
         STEP_W'(S_P + 1): c = mul_cmd(1'b0, lac_pkg::REG_TIME_STEP, lac_pkg::OPD_RATE, 1'b0);
         STEP_W'(S_P + 2): c = mul_cmd(1'b1, lac_pkg::REG_OBS_GAIN_POS, lac_pkg::OPD_E, 1'b1);
         STEP_W'(S_P + 3): c = mul_cmd(1'b0, lac_pkg::REG_OBS_GAIN_POS, lac_pkg::OPD_E, 1'b1);
         STEP_W'(S_P + 6): begin
            c.wb_en  = 1'b1;
            c.wb_dst = lac_pkg::WB_POS;
         end
         STEP_W'(S_R + 0): begin
            c = mul_cmd(1'b1, lac_pkg::REG_TIME_STEP, lac_pkg::OPD_DIST, 1'b0);
            c.acc_load = 1'b1;
            c.acc_src  = lac_pkg::ASRC_RATE;
         end
         STEP_W'(S_R + 1): c = mul_cmd(1'b0, lac_pkg::REG_TIME_STEP, lac_pkg::OPD_DIST, 1'b0);
         STEP_W'(S_R + 2): begin
            c = mul_cmd(1'b1, lac_pkg::REG_OBS_GAIN_RATE, lac_pkg::OPD_E, 1'b1);
            // The new position estimate is in place, so the control error can be formed.
            c.err_load = 1'b1;
         end
         STEP_W'(S_R + 3): c = mul_cmd(1'b0, lac_pkg::REG_OBS_GAIN_RATE, lac_pkg::OPD_E, 1'b1);
         STEP_W'(S_R + 4): c = mul_cmd(1'b1, lac_pkg::REG_INPUT_GAIN_STEP, lac_pkg::OPD_LAST,
                                       1'b0);
         STEP_W'(S_R + 5): c = mul_cmd(1'b0, lac_pkg::REG_INPUT_GAIN_STEP, lac_pkg::OPD_LAST,
                                       1'b0);
         STEP_W'(S_R + 8): begin
            c.wb_en  = 1'b1;
            c.wb_dst = lac_pkg::WB_RATE;
         end
         STEP_W'(S_D + 0): begin
            c = mul_cmd(1'b1, lac_pkg::REG_OBS_GAIN_DIST, lac_pkg::OPD_E, 1'b1);
            c.acc_load = 1'b1;
            c.acc_src  = lac_pkg::ASRC_DIST;
         end
         STEP_W'(S_D + 1): c = mul_cmd(1'b0, lac_pkg::REG_OBS_GAIN_DIST, lac_pkg::OPD_E, 1'b1);
         STEP_W'(S_D + 4): begin
            c.wb_en  = 1'b1;
            c.wb_dst = lac_pkg::WB_DIST;
         end
         STEP_W'(S_U0 + 0): begin
            c = mul_cmd(1'b1, lac_pkg::REG_PROP_GAIN, lac_pkg::OPD_ERR, 1'b0);
            c.acc_load = 1'b1;
            c.acc_src  = lac_pkg::ASRC_NEG_DIST;
         end
         STEP_W'(S_U0 + 1): c = mul_cmd(1'b0, lac_pkg::REG_PROP_GAIN, lac_pkg::OPD_ERR, 1'b0);
         STEP_W'(S_U0 + 2): c = mul_cmd(1'b1, lac_pkg::REG_DERIV_GAIN, lac_pkg::OPD_RATE, 1'b1);
         STEP_W'(S_U0 + 3): c = mul_cmd(1'b0, lac_pkg::REG_DERIV_GAIN, lac_pkg::OPD_RATE, 1'b1);
         STEP_W'(S_U0 + 6): begin
            c.wb_en  = 1'b1;
            c.wb_dst = lac_pkg::WB_U0;
         end
         STEP_W'(S_U + 0): begin
            c = mul_cmd(1'b1, lac_pkg::REG_INV_PLANT_GAIN, lac_pkg::OPD_U0, 1'b0);
            c.acc_load = 1'b1;
            c.acc_src  = lac_pkg::ASRC_ZERO;
         end
         STEP_W'(S_U + 1): c = mul_cmd(1'b0, lac_pkg::REG_INV_PLANT_GAIN, lac_pkg::OPD_U0, 1'b0);
         default: c = '0;
      endcase
      return c;
   endfunction

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.take = 1'b1;
            if (status.in_valid) begin
               state_in = ST_RUN;
               step_in  = '0;
            end
         end
         ST_RUN: begin
            cmd = ucode(step_ff);
            if (step_ff == STEP_LAST) begin
               // The final step waits here while the previous result is still held.
               if (status.out_free) begin
                  cmd.finish = 1'b1;
                  state_in   = ST_IDLE;
               end
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/lac_datapath.sv =====
// Observer and control-law datapath around one shared 48 by 17 bit multiplier.
`default_nettype none

module lac_datapath #(
   parameter int OUT_LIMIT = lac_pkg::OUT_LIMIT_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   lac_req_if.sink                   req_ch,
   lac_rsp_if.source                 rsp_ch,
   lac_csr_if.sink                   csr_ch,
   input  wire lac_pkg::lac_cmd_type cmd,
   output lac_pkg::lac_status_type   status
);

   localparam int DW     = lac_pkg::DATA_W;
   localparam int GW     = lac_pkg::GAIN_W;
   localparam int HALF_W = DW / 2 + 1;
   localparam int PROD_W = GW + HALF_W;
   localparam int PACC_W = GW + DW;
   localparam int SACC_W = DW + 26;
   localparam logic signed [PACC_W-1:0] ROUND   = PACC_W'(1) <<< 23;
   localparam logic signed [SACC_W-1:0] S32_MAX = (SACC_W'(1) <<< (DW - 1)) - SACC_W'(1);
   localparam logic signed [SACC_W-1:0] S32_MIN = -(SACC_W'(1) <<< (DW - 1));
   localparam logic signed [SACC_W-1:0] LIM     = SACC_W'(OUT_LIMIT) <<< 16;

   function automatic logic signed [DW-1:0] sat32(input logic signed [SACC_W-1:0] x);
      if (x > S32_MAX) begin
         return S32_MAX[DW-1:0];
      end else if (x < S32_MIN) begin
         return S32_MIN[DW-1:0];
      end
      return x[DW-1:0];
   endfunction

   // Configuration registers.
   logic signed [GW-1:0] gain_ff [lac_pkg::REG_COUNT];
   logic signed [GW-1:0] gain_in;
   logic                 csr_wr;

   // Loop state and per-item operands.
   logic signed [DW-1:0] est_position_ff, est_rate_ff, est_disturbance_ff, last_drive_ff;
   logic signed [DW-1:0] setpoint_ff, e_ff, err_ff, u0_ff;
   logic signed [DW-1:0] e_in, err_in, wb_val;
   logic                 req_acc;

   // Multiply and accumulate stages.
   logic signed [DW-1:0]     opnd;
   logic signed [HALF_W-1:0] half;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     prod_v_ff, prod_hi_ff, prod_neg_ff;
   logic signed [PACC_W-1:0] pacc_ff, pacc_in, pacc_rnd;
   logic                     pacc_done_ff, pacc_neg_ff;
   logic signed [SACC_W-1:0] sacc_ff, sacc_in, term;

   // Result register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [DW-1:0] drive_ff, drive_in;
   logic                 clamped_ff, clamped_in;

   assign csr_ch.ready = 1'b1;
   assign csr_wr  = csr_ch.valid && (csr_ch.index < lac_pkg::CSR_IDX_W'(lac_pkg::REG_COUNT));
   // The time step is unsigned, so its top bit always reads as zero.
   assign gain_in = (csr_ch.index[lac_pkg::REG_IDX_W-1:0] == lac_pkg::REG_TIME_STEP)
                    ? {1'b0, csr_ch.data[GW-2:0]} : csr_ch.data;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= lac_pkg::GAIN_RESET;
      end else if (csr_wr) begin
         gain_ff[csr_ch.index[lac_pkg::REG_IDX_W-1:0]] <= gain_in;
      end
   end

   assign req_ch.ready = cmd.take;
   assign req_acc      = req_ch.valid && cmd.take;
   assign e_in   = sat32(SACC_W'(est_position_ff) - SACC_W'(req_ch.measured));
   assign err_in = sat32(SACC_W'(setpoint_ff) - SACC_W'(est_position_ff));
   assign wb_val = sat32(sacc_ff);

   always_ff @(posedge clock) begin
      if (req_acc) begin
         setpoint_ff <= req_ch.setpoint;
         e_ff        <= e_in;
      end
      if (cmd.err_load) begin
         err_ff <= err_in;
      end
      if (cmd.wb_en && cmd.wb_dst == lac_pkg::WB_U0) begin
         u0_ff <= wb_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         est_position_ff    <= '0;
         est_rate_ff        <= '0;
         est_disturbance_ff <= '0;
         last_drive_ff      <= '0;
      end else begin
         if (cmd.wb_en) begin
            case (cmd.wb_dst)
               lac_pkg::WB_POS:  est_position_ff    <= wb_val;
               lac_pkg::WB_RATE: est_rate_ff        <= wb_val;
               lac_pkg::WB_DIST: est_disturbance_ff <= wb_val;
               default: ;
            endcase
         end
         if (cmd.finish) begin
            last_drive_ff <= drive_in;
         end
      end
   end

   // Stage one: a gain times the signed high or unsigned low half of an operand.
   always_comb begin
      case (cmd.opnd_sel)
         lac_pkg::OPD_RATE: opnd = est_rate_ff;
         lac_pkg::OPD_DIST: opnd = est_disturbance_ff;
         lac_pkg::OPD_E:    opnd = e_ff;
         lac_pkg::OPD_LAST: opnd = last_drive_ff;
         lac_pkg::OPD_ERR:  opnd = err_ff;
         lac_pkg::OPD_U0:   opnd = u0_ff;
         default:           opnd = '0;
      endcase
      half    = cmd.mul_hi ? {opnd[DW-1], opnd[DW-1:DW/2]} : {1'b0, opnd[DW/2-1:0]};
      prod_in = gain_ff[cmd.gain_sel] * half;
   end

   // Stage two assembles the exact product; stage three rounds it and adds it in.
   assign pacc_in  = prod_hi_ff ? (PACC_W'(prod_ff) <<< (DW / 2))
                                : (pacc_ff + PACC_W'(prod_ff));
   assign pacc_rnd = pacc_ff + ROUND;
   assign term     = SACC_W'(pacc_rnd >>> 24);

   always_comb begin
      sacc_in = sacc_ff;
      if (cmd.acc_load) begin
         case (cmd.acc_src)
            lac_pkg::ASRC_POS:      sacc_in = SACC_W'(est_position_ff);
            lac_pkg::ASRC_RATE:     sacc_in = SACC_W'(est_rate_ff);
            lac_pkg::ASRC_DIST:     sacc_in = SACC_W'(est_disturbance_ff);
            lac_pkg::ASRC_NEG_DIST: sacc_in = -SACC_W'(est_disturbance_ff);
            default:                sacc_in = '0;
         endcase
      end else if (pacc_done_ff) begin
         sacc_in = pacc_neg_ff ? (sacc_ff - term) : (sacc_ff + term);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_v_ff    <= 1'b0;
         pacc_done_ff <= 1'b0;
      end else begin
         prod_v_ff    <= cmd.mul_en;
         pacc_done_ff <= prod_v_ff && !prod_hi_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff     <= prod_in;
      prod_hi_ff  <= cmd.mul_hi;
      prod_neg_ff <= cmd.mul_neg;
      pacc_neg_ff <= prod_neg_ff;
      if (prod_v_ff) begin
         pacc_ff <= pacc_in;
      end
      sacc_ff <= sacc_in;
   end

   // Output clamp; a value exactly at the limit passes unflagged.
   always_comb begin
      drive_in   = sacc_ff[DW-1:0];
      clamped_in = 1'b0;
      if (sacc_ff > LIM) begin
         drive_in   = LIM[DW-1:0];
         clamped_in = 1'b1;
      end else if (sacc_ff < -LIM) begin
         drive_in   = -LIM[DW-1:0];
         clamped_in = 1'b1;
      end
   end

   assign rsp_valid_in = cmd.finish || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         drive_ff   <= drive_in;
         clamped_ff <= clamped_in;
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.drive   = drive_ff;
   assign rsp_ch.clamped = clamped_ff;

   assign status.in_valid = req_ch.valid;
   assign status.out_free = !rsp_valid_ff || rsp_ch.ready;

endmodule

`default_nettype wire

// ===== sv/linear_adrc_controller.sv =====
// Linear ADRC controller: extended state observer step and clamped PD drive per item.
//
// Usage. Each item on the req_ch channel carries a setpoint and a measured value in
// signed Q16.16. For every item accepted the block returns exactly one item on
// rsp_ch: the clamped drive in Q16.16 and a flag that is set when the limit acted.
// Gains are written through csr_ch (index 0 to 7 in the register order, 48-bit
// data; other indexes are ignored); csr_ch is always ready and should be written
// only while no item is in flight.
// Timing. An item is accepted in the idle cycle, and the next one only after the
// result of the last has been registered. The pace is set by the one shared 48 by
// 17 bit multiplier: nine gain products, two passes each, plus a drain of the
// accumulate stages at the end of each of the five sums.
// Reset. All gains return to their defaults, the three estimates and the remembered
// drive clear to zero, and no result is pending.
// Stall. A result is held in the output register until rsp_ch.ready; meanwhile the
// next item is accepted and worked on, and it waits at its final step until the
// output register is free.
`default_nettype none

module linear_adrc_controller #(
   parameter int OUT_LIMIT = lac_pkg::OUT_LIMIT_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   lac_req_if.sink    req_ch,
   lac_rsp_if.source  rsp_ch,
   lac_csr_if.sink    csr_ch
);

   lac_pkg::lac_cmd_type    cmd;
   lac_pkg::lac_status_type status;

   lac_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   lac_datapath #(
      .OUT_LIMIT (OUT_LIMIT)
   ) u_datapath (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch),
      .cmd    (cmd),
      .status (status)
   );

endmodule

`default_nettype wire

// ===== sv/lac_checker.sv =====
// Port-level assertions for the linear ADRC controller, bound to the top level.
`default_nettype none

module lac_checker #(
   parameter int OUT_LIMIT = lac_pkg::OUT_LIMIT_DEF
) (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_valid,
   input wire logic                           req_ready,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic signed [lac_pkg::DATA_W-1:0] rsp_drive,
   input wire logic                           rsp_clamped
);

   localparam logic signed [lac_pkg::DATA_W-1:0] LIM =
      lac_pkg::DATA_W'(OUT_LIMIT * 65536);

   // A waiting result item holds its value until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_drive) && $stable(rsp_clamped))
      else $error("result item changed or vanished while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_drive <= LIM) && (rsp_drive >= -LIM))
      else $error("drive outside the output limit");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clamped |-> (rsp_drive == LIM) || (rsp_drive == -LIM))
      else $error("clamp flag set but drive is not at the limit");

   // Items are worked one at a time, so an accept is never followed by another at once.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted on consecutive cycles");

endmodule

bind linear_adrc_controller lac_checker #(
   .OUT_LIMIT (OUT_LIMIT)
) u_lac_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_drive   (rsp_ch.drive),
   .rsp_clamped (rsp_ch.clamped)
);

`default_nettype wire

// ===== bench/linear_adrc_controller_tb.sv =====
// Self-checking testbench for the linear ADRC controller: directed table, then random items.
`timescale 1ns / 1ps

module linear_adrc_controller_tb;

   localparam int DRIVE_LIMIT = lac_pkg::OUT_LIMIT_DEF;
   localparam logic signed [lac_pkg::DATA_W-1:0] DRIVE_FULL = DRIVE_LIMIT * 65536;
   localparam logic signed [lac_pkg::DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [lac_pkg::DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
   localparam logic [lac_pkg::GAIN_W-1:0] UNITY_GAIN = 48'd16777216;
   localparam logic [lac_pkg::GAIN_W-1:0] GAIN_TOP = 48'h7FFF_FFFF_FFFF;
   localparam logic [lac_pkg::GAIN_W-1:0] GAIN_BOTTOM = 48'h8000_0000_0000;
   localparam int LATENCY_PAD = 40;
   localparam int STALL_LIMIT = 1000;
   localparam int PHASE_COUNT = 11;
   localparam int PHASE_ITEMS = 50;

   // Gain sets the run switches between.
   localparam int BANK_RESET = 0;
   localparam int BANK_DEFAULT = 1;
   localparam int BANK_UNITY = 2;
   localparam int BANK_MAX = 3;
   localparam int BANK_MIN = 4;
   localparam int BANK_RANDOM = 5;

   typedef struct packed {
      logic signed [lac_pkg::DATA_W-1:0] drive;
      logic                              clamped;
   } drive_result_type;

   typedef struct packed {
      logic [2:0]                        bank;
      logic signed [lac_pkg::DATA_W-1:0] setpoint;
      logic signed [lac_pkg::DATA_W-1:0] measured;
      logic                              typed;
      logic signed [lac_pkg::DATA_W-1:0] drive;
      logic                              clamped;
   } stim_row_type;

   logic clock;
   logic reset;

   lac_req_if req_ch ();
   lac_rsp_if rsp_ch ();
   lac_csr_if csr_ch ();

   linear_adrc_controller #(.OUT_LIMIT(DRIVE_LIMIT)) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Predictor copy of the gains and the observer state.
   logic [lac_pkg::GAIN_W-1:0]        gain_regs [lac_pkg::REG_COUNT];
   logic signed [lac_pkg::DATA_W-1:0] obs_pos;
   logic signed [lac_pkg::DATA_W-1:0] obs_rate;
   logic signed [lac_pkg::DATA_W-1:0] obs_dist;
   logic signed [lac_pkg::DATA_W-1:0] prev_drive;

   drive_result_type pending_drives [$];
   stim_row_type     directed_rows [$];
   drive_result_type want;
   int               mismatch_count = 0;
   int               results_seen = 0;
   int               rsp_hold = 0;
   bit               req_quiet = 1'b0;
   bit               rsp_quiet = 1'b0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic signed [lac_pkg::DATA_W-1:0] sat_word(input longint x);
      if (x > 64'sd2147483647) return WORD_MAX;
      if (x < -64'sd2147483648) return WORD_MIN;
      return x[lac_pkg::DATA_W-1:0];
   endfunction

   // Q24.24 gain times Q16.16 value, rounded half up back to Q16.16, kept wide.
   function automatic longint gain_mul(input logic signed [lac_pkg::GAIN_W-1:0] gain,
                                       input logic signed [lac_pkg::DATA_W-1:0] value);
      logic signed [79:0] product;
      product = gain * value;
      product = product + 80'sd8388608;
      return longint'(product >>> 24);
   endfunction

   function automatic void advance_adrc(input logic signed [lac_pkg::DATA_W-1:0] setpoint,
                                        input logic signed [lac_pkg::DATA_W-1:0] measured,
                                        output drive_result_type res);
      logic signed [lac_pkg::DATA_W-1:0] obs_err;
      logic signed [lac_pkg::DATA_W-1:0] track_err;
      longint p, r, d, u0, u, lim;
      obs_err = sat_word(longint'(obs_pos) - longint'(measured));
      p = longint'(obs_pos) + gain_mul(gain_regs[lac_pkg::REG_TIME_STEP], obs_rate)
          - gain_mul(gain_regs[lac_pkg::REG_OBS_GAIN_POS], obs_err);
      r = longint'(obs_rate) + gain_mul(gain_regs[lac_pkg::REG_TIME_STEP], obs_dist)
          - gain_mul(gain_regs[lac_pkg::REG_OBS_GAIN_RATE], obs_err)
          + gain_mul(gain_regs[lac_pkg::REG_INPUT_GAIN_STEP], prev_drive);
      d = longint'(obs_dist) - gain_mul(gain_regs[lac_pkg::REG_OBS_GAIN_DIST], obs_err);
      obs_pos = sat_word(p);
      obs_rate = sat_word(r);
      obs_dist = sat_word(d);
      track_err = sat_word(longint'(setpoint) - longint'(obs_pos));
      u0 = gain_mul(gain_regs[lac_pkg::REG_PROP_GAIN], track_err)
           - gain_mul(gain_regs[lac_pkg::REG_DERIV_GAIN], obs_rate) - longint'(obs_dist);
      u = gain_mul(gain_regs[lac_pkg::REG_INV_PLANT_GAIN], sat_word(u0));
      lim = longint'(DRIVE_LIMIT) * 65536;
      res.clamped = 1'b0;
      if (u > lim) begin
         u = lim;
         res.clamped = 1'b1;
      end
      if (u < -lim) begin
         u = -lim;
         res.clamped = 1'b1;
      end
      res.drive = u[lac_pkg::DATA_W-1:0];
      prev_drive = res.drive;
   endfunction

   function automatic logic signed [lac_pkg::DATA_W-1:0] pick_word();
      logic signed [lac_pkg::DATA_W-1:0] w;
      case ($urandom_range(0, 3))
         0: w = $urandom;
         1: begin
            w = $urandom >> $urandom_range(8, 30);
            if ($urandom_range(0, 1) == 1) w = -w;
         end
         2: begin
            case ($urandom_range(0, 4))
               0: w = WORD_MAX;
               1: w = WORD_MIN;
               2: w = 0;
               3: w = 1;
               default: w = -1;
            endcase
         end
         default: w = $urandom_range(0, 655360) - 327680;
      endcase
      return w;
   endfunction

   function automatic logic [lac_pkg::GAIN_W-1:0] random_gain(input int k);
      logic [lac_pkg::GAIN_W-1:0] g;
      case ($urandom_range(0, 4))
         0: g = lac_pkg::GAIN_W'({$urandom, $urandom});
         1: g = lac_pkg::GAIN_RESET[k] >>> $urandom_range(0, 6);
         2: g = lac_pkg::GAIN_RESET[k] << $urandom_range(0, 4);
         3: begin
            g = lac_pkg::GAIN_W'({$urandom, $urandom} >> $urandom_range(16, 60));
            if ($urandom_range(0, 1) == 1) g = -g;
         end
         default: g = ($urandom_range(0, 1) == 1) ? GAIN_TOP : GAIN_BOTTOM;
      endcase
      return g;
   endfunction

   task automatic note_mismatch(input string what);
      mismatch_count++;
      $display("MISMATCH at %0t: %s", $time, what);
   endtask

   task automatic add_row(input int bank, input logic signed [lac_pkg::DATA_W-1:0] setpoint,
                          input logic signed [lac_pkg::DATA_W-1:0] measured, input bit typed,
                          input logic signed [lac_pkg::DATA_W-1:0] drive, input bit clamped);
      stim_row_type row;
      row.bank = 3'(bank);
      row.setpoint = setpoint;
      row.measured = measured;
      row.typed = typed;
      row.drive = drive;
      row.clamped = clamped;
      directed_rows.push_back(row);
   endtask

   // Called at a falling edge; returns at the falling edge after the item is taken.
   task automatic send_item(input logic signed [lac_pkg::DATA_W-1:0] setpoint,
                            input logic signed [lac_pkg::DATA_W-1:0] measured, input bit typed,
                            input logic signed [lac_pkg::DATA_W-1:0] drive, input bit clamped);
      int gap;
      drive_result_type res;
      gap = req_quiet ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.setpoint = setpoint;
      req_ch.measured = measured;
      req_ch.valid = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      advance_adrc(setpoint, measured, res);
      if (typed) begin
         res.drive = drive;
         res.clamped = clamped;
      end
      pending_drives.push_back(res);
      @(negedge clock);
   endtask

   task automatic csr_write(input logic [lac_pkg::CSR_IDX_W-1:0] index,
                            input logic [lac_pkg::GAIN_W-1:0] data);
      csr_ch.index = index;
      csr_ch.data = data;
      csr_ch.valid = 1'b1;
      do @(posedge clock); while (!csr_ch.ready);
      if (index < lac_pkg::REG_COUNT) begin
         if (index == lac_pkg::REG_TIME_STEP)
            gain_regs[index[lac_pkg::REG_IDX_W-1:0]] = {1'b0, data[lac_pkg::GAIN_W-2:0]};
         else
            gain_regs[index[lac_pkg::REG_IDX_W-1:0]] = data;
      end
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   // Waits until the block is idle, then writes every gain plus one write to an unused index.
   task automatic load_bank(input int code);
      logic [lac_pkg::GAIN_W-1:0] bank [lac_pkg::REG_COUNT];
      int k;
      int stray_at;
      req_ch.valid = 1'b0;
      while (pending_drives.size() != 0) @(posedge clock);
      repeat (LATENCY_PAD) @(negedge clock);
      for (k = 0; k < lac_pkg::REG_COUNT; k++) begin
         case (code)
            BANK_DEFAULT: bank[k] = lac_pkg::GAIN_RESET[k];
            BANK_UNITY: bank[k] = '0;
            BANK_MAX: bank[k] = GAIN_TOP;
            BANK_MIN: bank[k] = GAIN_BOTTOM;
            default: bank[k] = random_gain(k);
         endcase
      end
      if (code == BANK_UNITY) begin
         bank[lac_pkg::REG_PROP_GAIN] = UNITY_GAIN;
         bank[lac_pkg::REG_INV_PLANT_GAIN] = UNITY_GAIN;
      end
      stray_at = $urandom_range(0, lac_pkg::REG_COUNT);
      for (k = 0; k <= lac_pkg::REG_COUNT; k++) begin
         if (k == stray_at)
            csr_write(lac_pkg::CSR_IDX_W'($urandom_range(lac_pkg::REG_COUNT,
                                                          2 ** lac_pkg::CSR_IDX_W - 1)),
                      lac_pkg::GAIN_W'({$urandom, $urandom}));
         if (k < lac_pkg::REG_COUNT) csr_write(k[lac_pkg::CSR_IDX_W-1:0], bank[k]);
      end
   endtask

   // Result side: ready drops for a drawn number of cycles after each item taken.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold > 0) begin
            rsp_ch.ready = 1'b0;
            rsp_hold--;
         end else begin
            rsp_ch.ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_seen++;
         if (pending_drives.size() == 0) begin
            note_mismatch($sformatf("result %0d unexpected: drive %0d clamped %0b",
                                    results_seen, rsp_ch.drive, rsp_ch.clamped));
         end else begin
            want = pending_drives.pop_front();
            if (rsp_ch.drive !== want.drive || rsp_ch.clamped !== want.clamped)
               note_mismatch($sformatf("result %0d: drive %0d clamped %0b, wanted %0d %0b",
                                       results_seen, rsp_ch.drive, rsp_ch.clamped,
                                       want.drive, want.clamped));
         end
         rsp_hold = rsp_quiet ? 0 : $urandom_range(0, 8);
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
             || (csr_ch.valid && csr_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("linear_adrc_controller: mismatch");
      $finish;
   end

   initial begin : stimulus
      int phase;
      int k;
      int current_bank;
      logic signed [lac_pkg::DATA_W-1:0] sp;
      logic signed [lac_pkg::DATA_W-1:0] ym;
      logic signed [lac_pkg::DATA_W-1:0] target;
      longint plant_pos;

      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.setpoint = '0;
      req_ch.measured = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.data = '0;
      for (k = 0; k < lac_pkg::REG_COUNT; k++) gain_regs[k] = lac_pkg::GAIN_RESET[k];
      obs_pos = '0;
      obs_rate = '0;
      obs_dist = '0;
      prev_drive = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Zero state and zero inputs straight after reset give a zero drive.
      add_row(BANK_RESET, 0, 0, 1'b1, 0, 1'b0);
      // With the observer gains at zero and unity scaling the drive is the setpoint,
      // so the clamp edges can be read off directly.
      add_row(BANK_UNITY, DRIVE_FULL, WORD_MAX, 1'b1, DRIVE_FULL, 1'b0);
      add_row(BANK_UNITY, DRIVE_FULL + 1, WORD_MIN, 1'b1, DRIVE_FULL, 1'b1);
      add_row(BANK_UNITY, -DRIVE_FULL, 32'sh5555_5555, 1'b1, -DRIVE_FULL, 1'b0);
      add_row(BANK_UNITY, -DRIVE_FULL - 1, 32'shAAAA_AAAA, 1'b1, -DRIVE_FULL, 1'b1);
      add_row(BANK_UNITY, WORD_MAX, 0, 1'b1, DRIVE_FULL, 1'b1);
      add_row(BANK_UNITY, WORD_MIN, -1, 1'b1, -DRIVE_FULL, 1'b1);
      add_row(BANK_UNITY, 100, 1, 1'b1, 100, 1'b0);
      add_row(BANK_UNITY, 0, 0, 1'b1, 0, 1'b0);
      // Default gains from a zero state: a full-scale setpoint drives the clamp.
      add_row(BANK_DEFAULT, WORD_MAX, 0, 1'b1, DRIVE_FULL, 1'b1);
      add_row(BANK_DEFAULT, WORD_MIN, 0, 1'b1, -DRIVE_FULL, 1'b1);
      add_row(BANK_DEFAULT, 0, WORD_MAX, 1'b0, 0, 1'b0);
      add_row(BANK_DEFAULT, 0, WORD_MIN, 1'b0, 0, 1'b0);
      add_row(BANK_DEFAULT, 65536, 65536, 1'b0, 0, 1'b0);
      add_row(BANK_DEFAULT, 32'sh5555_5555, 32'shAAAA_AAAA, 1'b0, 0, 1'b0);
      add_row(BANK_DEFAULT, 32'shAAAA_AAAA, 32'sh5555_5555, 1'b0, 0, 1'b0);
      // Extreme gains push every estimate and the control sum into saturation.
      add_row(BANK_MAX, WORD_MAX, WORD_MIN, 1'b0, 0, 1'b0);
      add_row(BANK_MAX, WORD_MIN, WORD_MAX, 1'b0, 0, 1'b0);
      add_row(BANK_MAX, 0, 0, 1'b0, 0, 1'b0);
      add_row(BANK_MIN, WORD_MIN, WORD_MAX, 1'b0, 0, 1'b0);
      add_row(BANK_MIN, WORD_MAX, WORD_MIN, 1'b0, 0, 1'b0);
      add_row(BANK_MIN, 1, -1, 1'b0, 0, 1'b0);

      current_bank = BANK_RESET;
      foreach (directed_rows[row]) begin
         if (directed_rows[row].bank != current_bank) begin
            current_bank = directed_rows[row].bank;
            load_bank(current_bank);
         end
         send_item(directed_rows[row].setpoint, directed_rows[row].measured,
                   directed_rows[row].typed, directed_rows[row].drive,
                   directed_rows[row].clamped);
      end

      plant_pos = 0;
      target = 0;
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0, 6, 10: load_bank(BANK_DEFAULT);
            3: load_bank(BANK_MAX);
            5: load_bank(BANK_MIN);
            8: load_bank(BANK_UNITY);
            default: load_bank(BANK_RANDOM);
         endcase
         for (k = 0; k < PHASE_ITEMS; k++) begin
            if (k % 25 == 0) begin
               req_quiet = ($urandom_range(0, 3) == 0);
               rsp_quiet = ($urandom_range(0, 3) == 0);
            end
            // Mostly a closed loop: a crude plant integrates the last drive, so the
            // observer sees measurements that follow its own output.
            if ($urandom_range(0, 9) < 7) begin
               if ($urandom_range(0, 19) == 0) target = pick_word();
               plant_pos = plant_pos + (longint'(prev_drive) >>> 2)
                           + longint'($urandom_range(0, 64)) - 32;
               ym = sat_word(plant_pos);
               plant_pos = longint'(ym);
               sp = target;
            end else begin
               sp = pick_word();
               ym = pick_word();
            end
            send_item(sp, ym, 1'b0, 0, 1'b0);
         end
      end

      req_ch.valid = 1'b0;
      while (pending_drives.size() != 0) @(posedge clock);
      repeat (LATENCY_PAD) @(posedge clock);
      if (mismatch_count == 0)
         $display("linear_adrc_controller: match");
      else
         $display("linear_adrc_controller: mismatch");
      $finish;
   end

endmodule
